// File: src/quaternion_vertex_transform_top_assert.svh
// Assertion macros for the quaternion vertex transform checker.
// Needs nothing beyond the including file's clock and reset names.
`ifndef QUATERNION_VERTEX_TRANSFORM_TOP_ASSERT_SVH
`define QUATERNION_VERTEX_TRANSFORM_TOP_ASSERT_SVH

// hold b in the cycle after a
`define QVT_ASSERT_NEXT(lbl, c, r, a, b) \
	lbl: assert property (@(posedge c) disable iff (!(r)) (a) |=> (b)) \
		else $error("qvt: next-cycle check failed");

// hold b in the same cycle as a
`define QVT_ASSERT_NOW(lbl, c, r, a, b) \
	lbl: assert property (@(posedge c) disable iff (!(r)) (a) |-> (b)) \
		else $error("qvt: same-cycle check failed");

`endif

// File: src/qvt_pkg.sv
// Shared widths, register codes, item types and rounding for the vertex transform.
// Used by every module of the block; depends on nothing.
`default_nettype none
package qvt_pkg;
	localparam int COORD_BITS       = 24;
	localparam int MATRIX_FRAC_BITS = 16;
	localparam int QUAT_BITS        = 16;
	localparam int SCALE_BITS       = 16;
	localparam int SCALE_FRAC       = 8;
	localparam int OFFSET_BITS      = 24;
	localparam int CFG_IDX_BITS     = 4;
	localparam int CFG_DATA_BITS    = 48;

	localparam int PROD_BITS   = 2 * QUAT_BITS;
	localparam int NORM_BITS   = 2 * QUAT_BITS + 1;
	localparam int NUM_BITS    = NORM_BITS + 2;
	localparam int QUO_BITS    = MATRIX_FRAC_BITS + 1;
	localparam int DIVD_BITS   = NORM_BITS + QUO_BITS;
	localparam int MAT_BITS    = MATRIX_FRAC_BITS + 2;
	localparam int SPROD_BITS  = COORD_BITS + SCALE_BITS;
	localparam int SCALED_BITS = SPROD_BITS - SCALE_FRAC;
	localparam int RPROD_BITS  = MAT_BITS + SCALED_BITS;
	localparam int ACC_BITS    = RPROD_BITS + 2;
	localparam int ROT_BITS    = ACC_BITS - MATRIX_FRAC_BITS + 1;
	localparam int SUM_BITS    = ROT_BITS + 1;

	localparam int QDEPTH     = 4;
	localparam int QPTR_BITS  = $clog2(QDEPTH);
	localparam int QCNT_BITS  = $clog2(QDEPTH + 1);
	localparam int ODEPTH     = 4;
	localparam int OPTR_BITS  = $clog2(ODEPTH);
	localparam int OCNT_BITS  = $clog2(ODEPTH + 1);

	localparam logic signed [COORD_BITS-1:0] COORD_MAX =
		COORD_BITS'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
	localparam logic signed [COORD_BITS-1:0] COORD_MIN = ~COORD_MAX;
	localparam logic signed [SUM_BITS-1:0] SAT_HI = SUM_BITS'(COORD_MAX);
	localparam logic signed [SUM_BITS-1:0] SAT_LO = SUM_BITS'(COORD_MIN);

	localparam logic [CFG_DATA_BITS-1:0] SCALE_RESET = 48'h0100_0100_0100;
	localparam logic signed [QUAT_BITS-1:0] QUAT_W_RESET = 16'sd16384;

	localparam logic [CFG_IDX_BITS-1:0] REG_QUAT_X   = 4'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_QUAT_Y   = 4'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_QUAT_Z   = 4'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_QUAT_W   = 4'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_SCALE    = 4'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_X = 4'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_Y = 4'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_Z = 4'd7;

	typedef logic [MAT_BITS-1:0] ment_t;
	typedef ment_t [8:0] matrix_t;

	typedef struct packed {
		logic signed [QUAT_BITS-1:0] x;
		logic signed [QUAT_BITS-1:0] y;
		logic signed [QUAT_BITS-1:0] z;
		logic signed [QUAT_BITS-1:0] w;
	} quat_t;

	typedef struct packed {
		logic [CFG_DATA_BITS-1:0]      scale;
		logic signed [OFFSET_BITS-1:0] ox;
		logic signed [OFFSET_BITS-1:0] oy;
		logic signed [OFFSET_BITS-1:0] oz;
	} xform_cfg_t;

	typedef struct packed {
		logic start;
		logic busy;
	} mat_ctrl_t;

	typedef struct packed {
		logic signed [SCALED_BITS-1:0] sx;
		logic signed [SCALED_BITS-1:0] sy;
		logic signed [SCALED_BITS-1:0] sz;
	} scaled_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] z;
		logic                         clip;
	} result_t;

	function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
		input int unsigned sh);
		logic [63:0] mag;
		logic [63:0] r;
		mag = v[63] ? (~v + 64'd1) : v;
		r = (mag + (64'd1 << (sh - 1))) >> sh;
		return v[63] ? -$signed(r) : $signed(r);
	endfunction
endpackage
`default_nettype wire

// File: src/qvt_matrix.sv
// Matrix builder: one shared multiplier for the quaternion products, then a
// single restoring divider reused for each entry. Depends on qvt_pkg.
`default_nettype none
module qvt_matrix import qvt_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire quat_t     quat,
	input  wire logic      start,
	output logic           busy,
	output matrix_t        mat
);
	typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_NORM, ST_LOAD, ST_DIV, ST_STORE} state_t;

	localparam int P_XX = 0, P_YY = 1, P_ZZ = 2, P_WW = 3, P_XY = 4;
	localparam int P_ZW = 5, P_XZ = 6, P_YW = 7, P_YZ = 8, P_XW = 9;
	localparam ment_t ONE = MAT_BITS'(1) << MATRIX_FRAC_BITS;

	state_t                      state_q;
	logic [4:0]                  cnt_q;
	logic [3:0]                  ent_q;
	logic signed [PROD_BITS-1:0] prod_q [10];
	logic [NORM_BITS-1:0]        n2_q;
	logic [NORM_BITS-1:0]        rem_q;
	logic [QUO_BITS-1:0]         dlo_q;
	logic [QUO_BITS-1:0]         quo_q;
	logic                        neg_q;
	matrix_t                     mat_q;

	logic signed [QUAT_BITS-1:0] op_a, op_b;
	logic signed [PROD_BITS-1:0] prod;
	logic [NORM_BITS-1:0]        n2_sum;
	logic signed [NUM_BITS-1:0]  nn, num;
	logic [NORM_BITS-1:0]        mag;
	logic [DIVD_BITS-1:0]        divd;
	logic [NORM_BITS+1:0]        trial;
	logic                        ge;
	logic [MAT_BITS-1:0]         q_ext, ent_val;

	always_comb begin
		case (cnt_q[3:0])
			4'd0: begin op_a = quat.x; op_b = quat.x; end
			4'd1: begin op_a = quat.y; op_b = quat.y; end
			4'd2: begin op_a = quat.z; op_b = quat.z; end
			4'd3: begin op_a = quat.w; op_b = quat.w; end
			4'd4: begin op_a = quat.x; op_b = quat.y; end
			4'd5: begin op_a = quat.z; op_b = quat.w; end
			4'd6: begin op_a = quat.x; op_b = quat.z; end
			4'd7: begin op_a = quat.y; op_b = quat.w; end
			4'd8: begin op_a = quat.y; op_b = quat.z; end
			4'd9: begin op_a = quat.x; op_b = quat.w; end
			default: begin op_a = quat.x; op_b = quat.x; end
		endcase
		prod = op_a * op_b;
		n2_sum = NORM_BITS'(unsigned'(prod_q[P_XX])) + NORM_BITS'(unsigned'(prod_q[P_YY]))
			+ NORM_BITS'(unsigned'(prod_q[P_ZZ])) + NORM_BITS'(unsigned'(prod_q[P_WW]));
		nn = $signed({2'b00, n2_q});
		case (ent_q)
			4'd0: num = nn - ((NUM_BITS'(prod_q[P_YY]) + NUM_BITS'(prod_q[P_ZZ])) <<< 1);
			4'd1: num = (NUM_BITS'(prod_q[P_XY]) - NUM_BITS'(prod_q[P_ZW])) <<< 1;
			4'd2: num = (NUM_BITS'(prod_q[P_XZ]) + NUM_BITS'(prod_q[P_YW])) <<< 1;
			4'd3: num = (NUM_BITS'(prod_q[P_XY]) + NUM_BITS'(prod_q[P_ZW])) <<< 1;
			4'd4: num = nn - ((NUM_BITS'(prod_q[P_XX]) + NUM_BITS'(prod_q[P_ZZ])) <<< 1);
			4'd5: num = (NUM_BITS'(prod_q[P_YZ]) - NUM_BITS'(prod_q[P_XW])) <<< 1;
			4'd6: num = (NUM_BITS'(prod_q[P_XZ]) - NUM_BITS'(prod_q[P_YW])) <<< 1;
			4'd7: num = (NUM_BITS'(prod_q[P_YZ]) + NUM_BITS'(prod_q[P_XW])) <<< 1;
			4'd8: num = nn - ((NUM_BITS'(prod_q[P_XX]) + NUM_BITS'(prod_q[P_YY])) <<< 1);
			default: num = '0;
		endcase
		mag = num[NUM_BITS-1] ? NORM_BITS'(-num) : NORM_BITS'(num);
		divd = DIVD_BITS'({mag, {MATRIX_FRAC_BITS{1'b0}}}) + DIVD_BITS'(n2_q >> 1);
		trial = {1'b0, rem_q, dlo_q[QUO_BITS-1]} - {2'b00, n2_q};
		ge = !trial[NORM_BITS+1];
		q_ext = {1'b0, quo_q};
		ent_val = neg_q ? (~q_ext + MAT_BITS'(1)) : q_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ent_q   <= '0;
			n2_q    <= '0;
			rem_q   <= '0;
			dlo_q   <= '0;
			quo_q   <= '0;
			neg_q   <= 1'b0;
			for (int i = 0; i < 10; i++) prod_q[i] <= '0;
			for (int i = 0; i < 9; i++) mat_q[i] <= (i % 4 == 0) ? ONE : '0;
		end else if (start) begin
			state_q <= ST_MUL;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: ;
				ST_MUL: begin
					prod_q[cnt_q[3:0]] <= prod;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd9) state_q <= ST_NORM;
				end
				ST_NORM: begin
					n2_q  <= n2_sum;
					ent_q <= '0;
					if (n2_sum == '0) begin
						for (int i = 0; i < 9; i++) mat_q[i] <= (i % 4 == 0) ? ONE : '0;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					rem_q   <= divd[DIVD_BITS-1:QUO_BITS];
					dlo_q   <= divd[QUO_BITS-1:0];
					neg_q   <= num[NUM_BITS-1];
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= ge ? trial[NORM_BITS-1:0]
						: {rem_q[NORM_BITS-2:0], dlo_q[QUO_BITS-1]};
					quo_q <= {quo_q[QUO_BITS-2:0], ge};
					dlo_q <= dlo_q << 1;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(QUO_BITS - 1)) state_q <= ST_STORE;
				end
				ST_STORE: begin
					mat_q[ent_q] <= ent_val;
					ent_q <= ent_q + 4'd1;
					state_q <= (ent_q == 4'd8) ? ST_IDLE : ST_LOAD;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign mat  = mat_q;
endmodule
`default_nettype wire

// File: src/qvt_front.sv
// Front end: configuration registers, item intake and per-axis scaling.
// Depends on qvt_pkg; feeds the item queue and starts the matrix builder.
`default_nettype none
module qvt_front import qvt_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic signed [COORD_BITS-1:0]  vertex_x,
	input  wire logic signed [COORD_BITS-1:0]  vertex_y,
	input  wire logic signed [COORD_BITS-1:0]  vertex_z,
	input  wire logic                          cfg_valid,
	input  wire logic [CFG_IDX_BITS-1:0]       cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]      cfg_data,
	input  wire logic                          busy,
	output mat_ctrl_t                          mctl,
	output quat_t                              quat,
	output xform_cfg_t                         xcfg,
	output logic                               q_wr,
	output scaled_t                            q_data,
	input  wire logic                          q_full
);
	quat_t                        quat_q;
	xform_cfg_t                   xcfg_q;
	logic                         v_s1;
	logic signed [SPROD_BITS-1:0] p_s1 [3];
	logic                         adv, accept;

	assign accept = push && !full;
	assign adv    = !v_s1 || !q_full;
	assign full   = busy || (v_s1 && q_full);
	assign q_wr   = v_s1 && !q_full;
	assign mctl.busy  = busy;
	assign mctl.start = cfg_valid
		&& (cfg_index inside {REG_QUAT_X, REG_QUAT_Y, REG_QUAT_Z, REG_QUAT_W});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_q <= '{x: '0, y: '0, z: '0, w: QUAT_W_RESET};
			xcfg_q <= '{scale: SCALE_RESET, ox: '0, oy: '0, oz: '0};
			v_s1   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_QUAT_X:   quat_q.x <= cfg_data[QUAT_BITS-1:0];
					REG_QUAT_Y:   quat_q.y <= cfg_data[QUAT_BITS-1:0];
					REG_QUAT_Z:   quat_q.z <= cfg_data[QUAT_BITS-1:0];
					REG_QUAT_W:   quat_q.w <= cfg_data[QUAT_BITS-1:0];
					REG_SCALE:    xcfg_q.scale <= cfg_data;
					REG_OFFSET_X: xcfg_q.ox <= cfg_data[OFFSET_BITS-1:0];
					REG_OFFSET_Y: xcfg_q.oy <= cfg_data[OFFSET_BITS-1:0];
					REG_OFFSET_Z: xcfg_q.oz <= cfg_data[OFFSET_BITS-1:0];
					default: ;
				endcase
			end
			if (adv) v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && accept) begin
			p_s1[0] <= vertex_x * $signed(xcfg_q.scale[SCALE_BITS-1:0]);
			p_s1[1] <= vertex_y * $signed(xcfg_q.scale[2*SCALE_BITS-1:SCALE_BITS]);
			p_s1[2] <= vertex_z * $signed(xcfg_q.scale[3*SCALE_BITS-1:2*SCALE_BITS]);
		end
	end

	assign q_data.sx = SCALED_BITS'(round_shift(64'(p_s1[0]), SCALE_FRAC));
	assign q_data.sy = SCALED_BITS'(round_shift(64'(p_s1[1]), SCALE_FRAC));
	assign q_data.sz = SCALED_BITS'(round_shift(64'(p_s1[2]), SCALE_FRAC));
	assign quat = quat_q;
	assign xcfg = xcfg_q;
endmodule
`default_nettype wire

// File: src/qvt_queue.sv
// Short item queue between the front end and the rotation pipeline.
// Depends on qvt_pkg.
`default_nettype none
module qvt_queue import qvt_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    wr,
	input  wire scaled_t wdata,
	output logic         full,
	input  wire logic    rd,
	output scaled_t      rdata,
	output logic         empty
);
	scaled_t              mem_q [QDEPTH];
	logic [QPTR_BITS-1:0] wptr_q, rptr_q;
	logic [QCNT_BITS-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) wptr_q <= wptr_q + 1'b1;
			if (rd) rptr_q <= rptr_q + 1'b1;
			cnt_q <= cnt_q + QCNT_BITS'(wr) - QCNT_BITS'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wptr_q] <= wdata;
	end

	assign rdata = mem_q[rptr_q];
	assign full  = (cnt_q == QCNT_BITS'(QDEPTH));
	assign empty = (cnt_q == '0);
endmodule
`default_nettype wire

// File: src/qvt_back.sv
// Back end: rotation by the kept matrix, rounding, translation, saturation
// and the result queue. Depends on qvt_pkg.
`default_nettype none
module qvt_back import qvt_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_empty,
	output logic                       q_rd,
	input  wire scaled_t               q_data,
	input  wire matrix_t               mat,
	input  wire xform_cfg_t            xcfg,
	output logic                       empty,
	input  wire logic                  pop,
	output logic signed [COORD_BITS-1:0] out_x,
	output logic signed [COORD_BITS-1:0] out_y,
	output logic signed [COORD_BITS-1:0] out_z,
	output logic                       clipped
);
	logic                          v_s1, v_s2, v_s3;
	logic signed [RPROD_BITS-1:0]  pr_s1 [9];
	logic signed [ACC_BITS-1:0]    acc_s2 [3];
	result_t                       res_s3;
	result_t                       ofifo_q [ODEPTH];
	logic [OPTR_BITS-1:0]          wptr_q, rptr_q;
	logic [OCNT_BITS-1:0]          cnt_q;

	logic                          adv, ofull, owr, ord;
	logic signed [SCALED_BITS-1:0] sv [3];
	logic signed [OFFSET_BITS-1:0] off [3];
	logic signed [ROT_BITS-1:0]    rot [3];
	logic signed [SUM_BITS-1:0]    sum [3];
	logic signed [COORD_BITS-1:0]  sat [3];
	logic [2:0]                    clp;

	assign ofull = (cnt_q == OCNT_BITS'(ODEPTH));
	assign adv   = !(v_s3 && ofull);
	assign owr   = v_s3 && !ofull;
	assign ord   = pop && !empty;
	assign q_rd  = !q_empty && adv;
	assign sv[0] = q_data.sx;
	assign sv[1] = q_data.sy;
	assign sv[2] = q_data.sz;
	assign off[0] = xcfg.ox;
	assign off[1] = xcfg.oy;
	assign off[2] = xcfg.oz;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rot[i] = ROT_BITS'(round_shift(64'(acc_s2[i]), MATRIX_FRAC_BITS));
			sum[i] = SUM_BITS'(rot[i]) + SUM_BITS'(off[i]);
			if (sum[i] > SAT_HI) begin
				sat[i] = COORD_MAX;
				clp[i] = 1'b1;
			end else if (sum[i] < SAT_LO) begin
				sat[i] = COORD_MIN;
				clp[i] = 1'b1;
			end else begin
				sat[i] = COORD_BITS'(sum[i]);
				clp[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (adv) begin
				v_s1 <= q_rd;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
			end
			if (owr) wptr_q <= wptr_q + 1'b1;
			if (ord) rptr_q <= rptr_q + 1'b1;
			cnt_q <= cnt_q + OCNT_BITS'(owr) - OCNT_BITS'(ord);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					pr_s1[3*i+j] <= $signed(mat[3*i+j]) * sv[j];
				end
				acc_s2[i] <= ACC_BITS'(pr_s1[3*i]) + ACC_BITS'(pr_s1[3*i+1])
					+ ACC_BITS'(pr_s1[3*i+2]);
			end
			res_s3 <= '{x: sat[0], y: sat[1], z: sat[2], clip: |clp};
		end
		if (owr) ofifo_q[wptr_q] <= res_s3;
	end

	assign empty   = (cnt_q == '0);
	assign out_x   = ofifo_q[rptr_q].x;
	assign out_y   = ofifo_q[rptr_q].y;
	assign out_z   = ofifo_q[rptr_q].z;
	assign clipped = ofifo_q[rptr_q].clip;
endmodule
`default_nettype wire

// File: src/quaternion_vertex_transform_top.sv
// Items pass scaling, item queue, product, sum and saturation registers and the
// result queue, 1 item per cycle when full is low. A quaternion write rebuilds
// the matrix with full high: products, norm, and load, divide, store per entry.
// Reset is asynchronous: queues empty, registers at defaults, matrix identity.
// Depends on qvt_pkg, qvt_front, qvt_matrix, qvt_queue and qvt_back.
`default_nettype none
module quaternion_vertex_transform_top import qvt_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic signed [COORD_BITS-1:0]  vertex_x,
	input  wire logic signed [COORD_BITS-1:0]  vertex_y,
	input  wire logic signed [COORD_BITS-1:0]  vertex_z,
	output logic                               empty,
	input  wire logic                          pop,
	output logic signed [COORD_BITS-1:0]       out_x,
	output logic signed [COORD_BITS-1:0]       out_y,
	output logic signed [COORD_BITS-1:0]       out_z,
	output logic                               clipped,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0]       cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]      cfg_data
);
	mat_ctrl_t  mctl;
	quat_t      quat;
	xform_cfg_t xcfg;
	matrix_t    mat;
	logic       busy, q_wr, q_full, q_rd, q_empty;
	scaled_t    q_wdata, q_rdata;

	assign cfg_ready = 1'b1;

	qvt_front u_front (
		.clk, .arst_n, .push, .full, .vertex_x, .vertex_y, .vertex_z,
		.cfg_valid(cfg_valid && cfg_ready), .cfg_index, .cfg_data,
		.busy, .mctl, .quat, .xcfg, .q_wr, .q_data(q_wdata), .q_full
	);

	qvt_matrix u_matrix (
		.clk, .arst_n, .quat, .start(mctl.start), .busy, .mat
	);

	qvt_queue u_queue (
		.clk, .arst_n, .wr(q_wr), .wdata(q_wdata), .full(q_full),
		.rd(q_rd), .rdata(q_rdata), .empty(q_empty)
	);

	qvt_back u_back (
		.clk, .arst_n, .q_empty, .q_rd, .q_data(q_rdata), .mat, .xcfg,
		.empty, .pop, .out_x, .out_y, .out_z, .clipped
	);
endmodule
`default_nettype wire

// File: src/qvt_checker.sv
// Port-level checker for the vertex transform, bound to the top level.
// Depends on qvt_pkg and the assertion macro header.
`default_nettype none
`include "quaternion_vertex_transform_top_assert.svh"
module qvt_checker import qvt_pkg::*; (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          full,
	input wire logic                          empty,
	input wire logic                          pop,
	input wire logic signed [COORD_BITS-1:0]  out_x,
	input wire logic signed [COORD_BITS-1:0]  out_y,
	input wire logic signed [COORD_BITS-1:0]  out_z,
	input wire logic                          clipped,
	input wire logic                          cfg_valid,
	input wire logic                          cfg_ready,
	input wire logic [CFG_IDX_BITS-1:0]       cfg_index
);
	logic quat_wr, rail;

	assign quat_wr = cfg_valid && cfg_ready
		&& (cfg_index inside {REG_QUAT_X, REG_QUAT_Y, REG_QUAT_Z, REG_QUAT_W});
	assign rail = out_x == COORD_MAX || out_x == COORD_MIN || out_y == COORD_MAX
		|| out_y == COORD_MIN || out_z == COORD_MAX || out_z == COORD_MIN;

	`QVT_ASSERT_NEXT(a_rebuild_blocks, clk, arst_n, quat_wr, full)
	`QVT_ASSERT_NOW(a_clip_on_rail, clk, arst_n, !empty && clipped, rail)
	`QVT_ASSERT_NEXT(a_result_holds, clk, arst_n, !empty && !pop,
		!empty && $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(clipped))
endmodule

bind quaternion_vertex_transform_top qvt_checker u_checker (.*);
`default_nettype wire

// File: test/tb_quaternion_vertex_transform_top.sv
// Self-checking bench for the quaternion vertex transform: random and directed vertices,
// register writes between phases, scoreboard of predicted coordinates and clip flag.
// Depends on qvt_pkg and quaternion_vertex_transform_top.
`default_nettype none
module tb_quaternion_vertex_transform_top;
	import qvt_pkg::*;

	typedef struct {
		logic signed [COORD_BITS-1:0] x, y, z;
	} vertex_t;

	typedef struct {
		logic signed [COORD_BITS-1:0] x, y, z;
		logic                         clip;
	} coord_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic signed [COORD_BITS-1:0] vertex_x = '0, vertex_y = '0, vertex_z = '0;
	logic empty;
	logic pop = 1'b0;
	logic signed [COORD_BITS-1:0] out_x, out_y, out_z;
	logic clipped;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	quaternion_vertex_transform_top dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	vertex_t    pending_vertices[$];
	coord_out_t expected_coords[$];
	int errors = 0;
	bit quiet = 1'b0;
	bit tx_hold = 1'b0;
	bit rx_hold_req = 1'b0;
	int tx_gap = 0, rx_gap = 0, rx_long = 0, stuck = 0;

	// predictor state
	logic signed [QUAT_BITS-1:0] q_x = '0, q_y = '0, q_z = '0, q_w = QUAT_W_RESET;
	logic [CFG_DATA_BITS-1:0] scale_p = SCALE_RESET;
	logic signed [OFFSET_BITS-1:0] offs_p[3] = '{default: '0};
	longint rot[9] = '{65536, 0, 0, 0, 65536, 0, 0, 0, 65536};

	function automatic longint round_ratio(longint num, longint den);
		longint mag;
		mag = (num < 0) ? -num : num;
		mag = ((mag <<< MATRIX_FRAC_BITS) + den / 2) / den;
		return (num < 0) ? -mag : mag;
	endfunction

	function automatic longint round_down(longint v, int sh);
		longint mag;
		mag = (v < 0) ? -v : v;
		mag = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
		return (v < 0) ? -mag : mag;
	endfunction

	task automatic build_rotation();
		longint x, y, z, w, xx, yy, zz, ww, n;
		x = q_x; y = q_y; z = q_z; w = q_w;
		xx = x * x; yy = y * y; zz = z * z; ww = w * w;
		n = xx + yy + zz + ww;
		if (n == 0) begin
			foreach (rot[i]) rot[i] = (i % 4 == 0) ? (64'sd1 <<< MATRIX_FRAC_BITS) : 0;
		end else begin
			rot[0] = round_ratio(n - 2 * (yy + zz), n);
			rot[1] = round_ratio(2 * (x * y - z * w), n);
			rot[2] = round_ratio(2 * (x * z + y * w), n);
			rot[3] = round_ratio(2 * (x * y + z * w), n);
			rot[4] = round_ratio(n - 2 * (xx + zz), n);
			rot[5] = round_ratio(2 * (y * z - x * w), n);
			rot[6] = round_ratio(2 * (x * z - y * w), n);
			rot[7] = round_ratio(2 * (y * z + x * w), n);
			rot[8] = round_ratio(n - 2 * (xx + yy), n);
		end
	endtask

	task automatic apply_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
		case (idx)
			REG_QUAT_X: begin q_x = d[15:0]; build_rotation(); end
			REG_QUAT_Y: begin q_y = d[15:0]; build_rotation(); end
			REG_QUAT_Z: begin q_z = d[15:0]; build_rotation(); end
			REG_QUAT_W: begin q_w = d[15:0]; build_rotation(); end
			REG_SCALE: scale_p = d;
			REG_OFFSET_X: offs_p[0] = d[23:0];
			REG_OFFSET_Y: offs_p[1] = d[23:0];
			REG_OFFSET_Z: offs_p[2] = d[23:0];
			default: ;
		endcase
	endtask

	function automatic coord_out_t transform_vertex(vertex_t v);
		longint vin[3], s[3], acc, r, k;
		longint hi, lo;
		coord_out_t o;
		logic signed [COORD_BITS-1:0] res[3];
		hi = longint'(COORD_MAX);
		lo = longint'(COORD_MIN);
		vin[0] = v.x; vin[1] = v.y; vin[2] = v.z;
		o.clip = 1'b0;
		for (int i = 0; i < 3; i++) begin
			k = longint'($signed(scale_p[16*i +: 16]));
			s[i] = round_down(vin[i] * k, SCALE_FRAC);
		end
		for (int i = 0; i < 3; i++) begin
			acc = rot[3*i] * s[0] + rot[3*i+1] * s[1] + rot[3*i+2] * s[2];
			r = round_down(acc, MATRIX_FRAC_BITS) + longint'(offs_p[i]);
			if (r > hi) begin r = hi; o.clip = 1'b1; end
			if (r < lo) begin r = lo; o.clip = 1'b1; end
			res[i] = r[COORD_BITS-1:0];
		end
		o.x = res[0]; o.y = res[1]; o.z = res[2];
		return o;
	endfunction

	task automatic report(string field, longint got, longint want);
		$display("%0t: %s got %0d want %0d", $time, field, got, want);
		errors++;
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				expected_coords.insert(expected_coords.size(),
					transform_vertex(pending_vertices.pop_front()));
			if (tx_gap > 0)
				tx_gap--;
			else if (!quiet && $urandom_range(0, 24) == 0)
				tx_gap = $urandom_range(1, 17);
			if (tx_gap == 0 && !tx_hold && pending_vertices.size() > 0) begin
				push <= 1'b1;
				vertex_x <= pending_vertices[0].x;
				vertex_y <= pending_vertices[0].y;
				vertex_z <= pending_vertices[0].z;
			end else
				push <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		coord_out_t e;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_coords.size() == 0) begin
					report("unexpected item out_x", out_x, 0);
				end else begin
					e = expected_coords.pop_front();
					if (out_x !== e.x) report("out_x", out_x, e.x);
					if (out_y !== e.y) report("out_y", out_y, e.y);
					if (out_z !== e.z) report("out_z", out_z, e.z);
					if (clipped !== e.clip) report("clipped", clipped, e.clip);
				end
			end
			if (rx_long > 0)
				rx_long--;
			else if (rx_hold_req) begin
				rx_long = 400;
				rx_hold_req = 1'b0;
			end
			if (rx_gap > 0)
				rx_gap--;
			else if (!quiet && $urandom_range(0, 24) == 0)
				rx_gap = $urandom_range(1, 17);
			pop <= (rx_long == 0 && rx_gap == 0);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			stuck = 0;
		else if (++stuck >= 3000) begin
			$display("quaternion_vertex_transform_top: mismatch");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, d);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		@(negedge clk);
		while (pending_vertices.size() > 0 || expected_coords.size() > 0 || push)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic add_vertex(longint x, longint y, longint z);
		vertex_t v;
		v.x = x[COORD_BITS-1:0];
		v.y = y[COORD_BITS-1:0];
		v.z = z[COORD_BITS-1:0];
		pending_vertices.insert(pending_vertices.size(), v);
	endtask

	function automatic longint rand_coord();
		case ($urandom_range(0, 3))
			0: return longint'($signed(COORD_BITS'($urandom)));
			1: return $signed(32'($urandom_range(0, 32'h3FFFF))) - 32'sh20000;
			2: return $urandom_range(0, 1) ? longint'(COORD_MAX) : longint'(COORD_MIN);
			default: return $signed(32'($urandom_range(0, 32'h3FFF))) - 32'sh2000;
		endcase
	endfunction

	function automatic logic [15:0] rand_quat();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'($urandom);
			default: return 16'($urandom_range(0, 200) - 100);
		endcase
	endfunction

	function automatic logic [15:0] rand_scale();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom);
			default: return 16'($urandom_range(0, 16'h400) - 16'h200);
		endcase
	endfunction

	function automatic logic [23:0] rand_offset();
		case ($urandom_range(0, 4))
			0: return 24'h800000;
			1: return 24'h7FFFFF;
			2: return 24'($urandom);
			default: return 24'($urandom_range(0, 24'h20000) - 24'h10000);
		endcase
	endfunction

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// defaults: identity, unit scale
		add_vertex(0, 0, 0);
		add_vertex(longint'(COORD_MAX), longint'(COORD_MAX), longint'(COORD_MAX));
		add_vertex(longint'(COORD_MIN), longint'(COORD_MIN), longint'(COORD_MIN));
		add_vertex(longint'(COORD_MAX), longint'(COORD_MIN), -1);
		add_vertex(1, -1, 256);
		settle();

		// ignored indexes, zero quaternion, extremes of scale and offset
		write_reg(4'd8, 48'hFFFF_FFFF_FFFF);
		write_reg(4'd15, 48'h1234_5678_9ABC);
		write_reg(REG_QUAT_W, 48'd0);
		write_reg(REG_SCALE, 48'h8000_7FFF_8000);
		write_reg(REG_OFFSET_X, 48'h7FFFFF);
		write_reg(REG_OFFSET_Y, 48'h800000);
		write_reg(REG_OFFSET_Z, 48'h000001);
		add_vertex(0, 0, 0);
		add_vertex(longint'(COORD_MAX), longint'(COORD_MAX), longint'(COORD_MAX));
		add_vertex(longint'(COORD_MIN), longint'(COORD_MIN), longint'(COORD_MIN));
		add_vertex(-1, 1, -128);
		settle();

		// extreme quaternions
		write_reg(REG_QUAT_X, 48'h8000);
		write_reg(REG_QUAT_Y, 48'h7FFF);
		write_reg(REG_QUAT_Z, 48'h8000);
		write_reg(REG_QUAT_W, 48'h7FFF);
		write_reg(REG_SCALE, SCALE_RESET);
		write_reg(REG_OFFSET_X, 48'd0);
		write_reg(REG_OFFSET_Y, 48'd0);
		write_reg(REG_OFFSET_Z, 48'd0);
		add_vertex(1000, -2000, 3000);
		add_vertex(longint'(COORD_MAX), 0, longint'(COORD_MIN));
		add_vertex(-5, 7, 9);
		settle();

		for (int ph = 0; ph < 16; ph++) begin
			if (ph == 15)
				quiet = 1'b1;
			write_reg(REG_QUAT_X, 48'($signed(rand_quat())));
			write_reg(REG_QUAT_Y, 48'($signed(rand_quat())));
			write_reg(REG_QUAT_Z, 48'($signed(rand_quat())));
			write_reg(REG_QUAT_W, 48'($signed(rand_quat())));
			write_reg(REG_SCALE, {rand_scale(), rand_scale(), rand_scale()});
			write_reg(REG_OFFSET_X, 48'(rand_offset()));
			write_reg(REG_OFFSET_Y, 48'(rand_offset()));
			write_reg(REG_OFFSET_Z, 48'(rand_offset()));
			if ($urandom_range(0, 3) == 0)
				write_reg(4'($urandom_range(8, 15)), 48'({$urandom, $urandom}));
			if (ph == 3)
				rx_hold_req = 1'b1;
			if (ph == 7)
				tx_hold = 1'b1;
			for (int i = 0; i < 100; i++) begin
				add_vertex(rand_coord(), rand_coord(), rand_coord());
				if (ph == 7 && i == 49) begin
					tx_hold = 1'b0;
					while (pending_vertices.size() > 0 || expected_coords.size() > 0)
						@(negedge clk);
					tx_hold = 1'b1;
				end
			end
			tx_hold = 1'b0;
			settle();
		end

		repeat (20) @(posedge clk);
		if (errors == 0 && expected_coords.size() == 0)
			$display("quaternion_vertex_transform_top: match");
		else
			$display("quaternion_vertex_transform_top: mismatch");
		$finish;
	end
endmodule
`default_nettype wire

// File: sim.f
+incdir+src
src/qvt_pkg.sv
src/qvt_matrix.sv
src/qvt_front.sv
src/qvt_queue.sv
src/qvt_back.sv
src/quaternion_vertex_transform_top.sv
src/qvt_checker.sv
test/tb_quaternion_vertex_transform_top.sv
